>>> rtl/bpq_pkg.sv
// ---------------------------------------------------------------------------
// bpq_pkg
// Shared types and codes of the bounded priority queue: request and status
// codes, the stored entry, the request and the result item.
// ---------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

    // request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_DELETE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // width of the count fields of a result item
    localparam int CNT_OUT_W = 5;

    // one queue entry as stored
    typedef struct packed {
        logic [15:0]       tag;
        logic signed [7:0] pri;
    } t_entry;

    // one accepted request
    typedef struct packed {
        logic [1:0]        req_type;
        logic [15:0]       tag;
        logic signed [7:0] pri;
    } t_request;

    // one result item
    typedef struct packed {
        logic [1:0]           status;
        logic [15:0]          out_tag;
        logic signed [7:0]    out_priority;
        logic [CNT_OUT_W-1:0] removed_count;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/bpq_if.sv
// ---------------------------------------------------------------------------
// bpq_if
// Valid/ready channels of the priority queue: request items in, result
// items out.
// ---------------------------------------------------------------------------
`default_nettype none

interface bpq_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [15:0]       tag;
    logic signed [7:0] priority_req;

    modport source (output valid, output req_type, output tag, output priority_req,
                    input ready);
    modport sink   (input valid, input req_type, input tag, input priority_req,
                    output ready);
endinterface

interface bpq_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [15:0]       out_tag;
    logic signed [7:0] out_priority;
    logic [4:0]        removed_count;
    logic [4:0]        entry_count;

    modport source (output valid, output status, output out_tag, output out_priority,
                    output removed_count, output entry_count, input ready);
    modport sink   (input valid, input status, input out_tag, input out_priority,
                    input removed_count, input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/bpq_ram.sv
// ---------------------------------------------------------------------------
// bpq_ram
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bpq_ram
    import bpq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/bpq_seq.sv
// ---------------------------------------------------------------------------
// bpq_seq
// Request sequencer: walks the entry store one entry a cycle through a
// single priority comparator, moving entries for pop, insert and delete.
// ---------------------------------------------------------------------------
`default_nettype none

module bpq_seq
    import bpq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_request      i_req,
    input  wire logic          i_take,
    output logic               o_idle,
    output logic               o_done,
    output t_result            o_result,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output t_entry             o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire t_entry        i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TAIL = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    t_state            r_state,   n_state;
    t_request          r_req,     n_req;
    logic [CW-1:0]     r_count,   n_count;
    logic [CW-1:0]     r_issue,   n_issue;
    logic              r_pend,    n_pend;
    logic [CW-1:0]     r_pidx,    n_pidx;
    logic [CW-1:0]     r_wr,      n_wr;
    logic              r_found,   n_found;
    t_entry            r_carry,   n_carry;
    logic [CW-1:0]     r_removed, n_removed;
    logic [1:0]        r_status,  n_status;
    logic [15:0]       r_otag,    n_otag;
    logic signed [7:0] r_opri,    n_opri;

    logic              w_lt;
    logic              w_eq;
    logic [CW-1:0]     w_wr_idx;
    logic [CW-1:0]     w_rd_idx;
    t_entry            w_new;

    // shared priority comparator
    assign w_lt  = $signed(i_rd_data.pri) < $signed(r_req.pri);
    assign w_eq  = i_rd_data.pri == r_req.pri;
    assign w_new = '{tag: r_req.tag, pri: r_req.pri};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_count   = r_count;
        n_issue   = r_issue;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_wr      = r_wr;
        n_found   = r_found;
        n_carry   = r_carry;
        n_removed = r_removed;
        n_status  = r_status;
        n_otag    = r_otag;
        n_opri    = r_opri;
        o_wr_en   = 1'b0;
        w_wr_idx  = '0;
        o_wr_data = w_new;
        o_rd_en   = 1'b0;
        w_rd_idx  = r_issue;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req     = i_req;
                    n_status  = ST_OK;
                    n_otag    = '0;
                    n_opri    = '0;
                    n_removed = '0;
                    n_issue   = '0;
                    n_wr      = '0;
                    n_found   = 1'b0;
                    n_state   = S_SCAN;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            n_state = S_RESP;
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                w_wr_idx  = r_count;
                                o_wr_data = '{tag: i_req.tag, pri: 8'sd0};
                                n_count   = r_count + ONE_CNT;
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end
                        end
                        REQ_INSERT: begin
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read
                if (r_issue != r_count) begin
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_pidx  = r_issue;
                    n_issue = r_issue + ONE_CNT;
                end
                // handle the entry read last cycle
                if (r_pend) begin
                    case (r_req.req_type)
                        REQ_POP: begin
                            if (r_pidx == '0) begin
                                n_otag = i_rd_data.tag;
                                n_opri = i_rd_data.pri;
                            end else begin
                                o_wr_en   = 1'b1;
                                w_wr_idx  = r_pidx - ONE_CNT;
                                o_wr_data = i_rd_data;
                            end
                        end
                        REQ_INSERT: begin
                            if (r_found) begin
                                o_wr_en   = 1'b1;
                                w_wr_idx  = r_pidx;
                                o_wr_data = r_carry;
                                n_carry   = i_rd_data;
                            end else if (w_lt) begin
                                o_wr_en   = 1'b1;
                                w_wr_idx  = r_pidx;
                                o_wr_data = w_new;
                                n_carry   = i_rd_data;
                                n_found   = 1'b1;
                            end
                        end
                        default: begin
                            if (w_eq) begin
                                n_removed = r_removed + ONE_CNT;
                            end else begin
                                o_wr_en   = 1'b1;
                                w_wr_idx  = r_wr;
                                o_wr_data = i_rd_data;
                                n_wr      = r_wr + ONE_CNT;
                            end
                        end
                    endcase
                end
                // all entries walked
                if (!r_pend && r_issue == r_count) begin
                    case (r_req.req_type)
                        REQ_POP: begin
                            n_count   = r_count - ONE_CNT;
                            n_removed = ONE_CNT;
                            n_state   = S_RESP;
                        end
                        REQ_INSERT: begin
                            n_state = S_TAIL;
                        end
                        default: begin
                            n_count = r_wr;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_TAIL: begin
                // last entry of an insert goes to the tail
                o_wr_en   = 1'b1;
                w_wr_idx  = r_count;
                o_wr_data = r_found ? r_carry : w_new;
                n_count   = r_count + ONE_CNT;
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_addr = w_wr_idx[AW-1:0];
    assign o_rd_addr = w_rd_idx[AW-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_issue   <= n_issue;
        r_pidx    <= n_pidx;
        r_wr      <= n_wr;
        r_found   <= n_found;
        r_carry   <= n_carry;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_otag    <= n_otag;
        r_opri    <= n_opri;
    end

    // result
    assign o_idle                 = r_state == S_IDLE;
    assign o_done                 = r_state == S_RESP;
    assign o_result.status        = r_status;
    assign o_result.out_tag       = r_otag;
    assign o_result.out_priority  = r_opri;
    assign o_result.removed_count = CNT_OUT_W'(r_removed);
    assign o_result.entry_count   = CNT_OUT_W'(r_count);

endmodule

`default_nettype wire

>>> rtl/bounded_priority_queue_core.sv
// ---------------------------------------------------------------------------
// bounded_priority_queue_core
// Bounded queue of tagged entries with push to the tail, pop, insert by
// priority and delete by priority; one result item per request.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_req    in   valid / ready  req_type, tag, priority_req
//  o_rsp    out  valid / ready  status, out_tag, out_priority,
//                               removed_count, entry_count
//
//  push and rejected requests go straight to the result; pop and delete
//  walk the held entries, insert walks them and then writes the tail;
//  one store read a cycle sets the pace of the walk.
//  i_req.ready is high only between requests; one request at a time.
//  a finished result waits in the output register while the next request
//  is taken; the sequencer holds a later result until that register frees.
//  synchronous active-low reset empties the queue; entries are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_priority_queue_core
    import bpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpq_req_if.sink    i_req,
    bpq_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_request      w_req;
    t_result       w_result;
    t_result       r_out;
    logic          r_out_valid;
    logic          w_idle;
    logic          w_done;
    logic          w_take;
    logic          w_start;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;

    // request handshake
    assign i_req.ready = w_idle;
    assign w_start     = i_req.valid && w_idle;
    assign w_req       = '{req_type: i_req.req_type, tag: i_req.tag,
                           pri: i_req.priority_req};

    // output register frees when empty or taken
    assign w_take = !r_out_valid || o_rsp.ready;

    bpq_seq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_req     (w_req),
        .i_take    (w_take),
        .o_idle    (w_idle),
        .o_done    (w_done),
        .o_result  (w_result),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    bpq_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_done;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_take && w_done) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.out_tag       = r_out.out_tag;
    assign o_rsp.out_priority  = r_out.out_priority;
    assign o_rsp.removed_count = r_out.removed_count;
    assign o_rsp.entry_count   = r_out.entry_count;

`ifndef NO_ASSERTIONS
    // a request closes the door until its result is produced
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one in progress");

    // empty pop reports nothing removed and an empty queue
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |->
        (o_rsp.entry_count == '0 && o_rsp.removed_count == '0 && o_rsp.out_tag == '0))
        else $error("empty pop result inconsistent");

    // full add reports a full queue and no change
    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |->
        (o_rsp.entry_count == CNT_OUT_W'(QUEUE_DEPTH) && o_rsp.removed_count == '0))
        else $error("full add result inconsistent");
`endif

endmodule

`default_nettype wire

>>> test/bounded_priority_queue_core_tb.sv
// ---------------------------------------------------------------------------
// bounded_priority_queue_core_tb
// Self-checking bench for the bounded priority queue. Request items go in
// through a valid/ready driver fed from a backlog queue. A predictor keeps
// its own copy of the entry array and works out the reply to each
// accepted request. A monitor compares every reply item field by field with
// the oldest prediction. Both sides idle at random, and there is one long
// stretch with no idling. The receiver holds off once so that the core
// fills up and stalls its input. The sender drains between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_priority_queue_core_tb;
    import bpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    logic i_clk;
    logic i_rst_n;

    bpq_req_if req_ch ();
    bpq_rsp_if rsp_ch ();

    bounded_priority_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predicted queue contents
    logic [15:0]       shadow_tags [DEPTH];
    logic signed [7:0] shadow_pris [DEPTH];
    int                shadow_len;

    // stimulus and expectations
    t_request request_backlog [$];
    t_result  replies_due [$];
    bit       req_taken;
    int       idle_pct;
    int       rx_hold_left;

    // bookkeeping
    int mismatches;
    int ops_seen [4];
    int full_rejects;
    int empty_pops;
    int delete_hits;
    int peak_fill;

    // predictor: apply one request to the shadow queue, return its reply
    function automatic t_result queue_apply(t_request rq);
        t_result res;
        int      pos;
        int      w;
        res = '0;
        case (rq.req_type)
            REQ_PUSH: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_tags[shadow_len] = rq.tag;
                    shadow_pris[shadow_len] = 8'sd0;
                    shadow_len++;
                end
            end
            REQ_POP: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_tag      = shadow_tags[0];
                    res.out_priority = shadow_pris[0];
                    for (int i = 1; i < shadow_len; i++) begin
                        shadow_tags[i-1] = shadow_tags[i];
                        shadow_pris[i-1] = shadow_pris[i];
                    end
                    shadow_len--;
                    res.removed_count = 1;
                end
            end
            REQ_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // first entry of lower priority, else the tail
                    pos = shadow_len;
                    for (int i = shadow_len - 1; i >= 0; i--) begin
                        if (shadow_pris[i] < rq.pri) pos = i;
                    end
                    for (int i = shadow_len; i > pos; i--) begin
                        shadow_tags[i] = shadow_tags[i-1];
                        shadow_pris[i] = shadow_pris[i-1];
                    end
                    shadow_tags[pos] = rq.tag;
                    shadow_pris[pos] = rq.pri;
                    shadow_len++;
                end
            end
            default: begin
                // drop matching entries and compact in order
                w = 0;
                for (int i = 0; i < shadow_len; i++) begin
                    if (shadow_pris[i] == rq.pri) begin
                        res.removed_count = res.removed_count + 1'b1;
                    end else begin
                        shadow_tags[w] = shadow_tags[i];
                        shadow_pris[w] = shadow_pris[i];
                        w++;
                    end
                end
                shadow_len = w;
            end
        endcase
        res.entry_count = shadow_len[CNT_OUT_W-1:0];
        return res;
    endfunction

    // priorities drawn mostly from a small pool so deletes and ties hit
    function automatic logic signed [7:0] pick_priority();
        logic signed [7:0] p;
        case ($urandom_range(9))
            0:       p = 8'sd0;
            1:       p = 8'sd1;
            2:       p = -8'sd1;
            3:       p = 8'sd2;
            4:       p = 8'sd127;
            5:       p = -8'sd128;
            default: p = 8'($urandom_range(255));
        endcase
        return p;
    endfunction

    // queue n random requests with the given operation weights (percent)
    task automatic queue_random(int n, int push_w, int pop_w, int ins_w);
        t_request rq;
        int       r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < push_w) rq.req_type = REQ_PUSH;
            else if (r < push_w + pop_w) rq.req_type = REQ_POP;
            else if (r < push_w + pop_w + ins_w) rq.req_type = REQ_INSERT;
            else rq.req_type = REQ_DELETE;
            rq.tag = 16'($urandom_range(65535));
            rq.pri = pick_priority();
            request_backlog.push_back(rq);
        end
    endtask

    task automatic queue_one(logic [1:0] op, logic [15:0] tg, logic signed [7:0] pr);
        t_request rq;
        rq.req_type = op;
        rq.tag      = tg;
        rq.pri      = pr;
        request_backlog.push_back(rq);
    endtask

    // wait until every queued request has been answered
    task automatic wait_drained();
        while (request_backlog.size() != 0 || req_ch.valid || replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin : drive_requests
        t_request rq;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_taken = 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            req_taken = 1'b0;
            if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                rq = request_backlog.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.req_type     <= rq.req_type;
                req_ch.tag          <= rq.tag;
                req_ch.priority_req <= rq.pri;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // reply receiver, with an optional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // monitor: check replies, predict accepted requests
    always @(posedge i_clk) begin : check_and_predict
        t_result  want;
        t_result  got;
        t_request rq;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status        = rsp_ch.status;
                got.out_tag       = rsp_ch.out_tag;
                got.out_priority  = rsp_ch.out_priority;
                got.removed_count = rsp_ch.removed_count;
                got.entry_count   = rsp_ch.entry_count;
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected reply item st=%0d tag=%h pri=%0d rm=%0d n=%0d",
                                 $realtime, got.status, got.out_tag, got.out_priority,
                                 got.removed_count, got.entry_count);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.out_tag !== want.out_tag ||
                        got.out_priority !== want.out_priority ||
                        got.removed_count !== want.removed_count ||
                        got.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: reply mismatch", $realtime);
                            $display("  expected st=%0d tag=%h pri=%0d rm=%0d n=%0d",
                                     want.status, want.out_tag, want.out_priority,
                                     want.removed_count, want.entry_count);
                            $display("  actual   st=%0d tag=%h pri=%0d rm=%0d n=%0d",
                                     got.status, got.out_tag, got.out_priority,
                                     got.removed_count, got.entry_count);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                rq.req_type = req_ch.req_type;
                rq.tag      = req_ch.tag;
                rq.pri      = req_ch.priority_req;
                want = queue_apply(rq);
                replies_due.push_back(want);
                req_taken = 1'b1;
                ops_seen[rq.req_type]++;
                if (want.status == ST_FULL) full_rejects++;
                if (want.status == ST_EMPTY) empty_pops++;
                if (rq.req_type == REQ_DELETE && want.removed_count != 0) delete_hits++;
                if (shadow_len > peak_fill) peak_fill = shadow_len;
            end
        end
    end

    // main sequence
    initial begin : run_sequence
        logic signed [7:0] fill_pris [10];
        fill_pris = '{8'sd5, -8'sd5, 8'sd127, -8'sd128, 8'sd0,
                      8'sd64, -8'sd64, 8'sd1, -8'sd1, 8'sd0};
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_PUSH;
        req_ch.tag          = '0;
        req_ch.priority_req = '0;
        rsp_ch.ready        = 1'b0;
        req_taken           = 1'b0;
        idle_pct            = 38;
        rx_hold_left        = 0;
        mismatches          = 0;
        full_rejects        = 0;
        empty_pops          = 0;
        delete_hits         = 0;
        peak_fill           = 0;
        ops_seen            = '{default: 0};
        shadow_len          = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_tags[i] = '0;
            shadow_pris[i] = '0;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, field extremes, ties, full queue, deletes
        queue_one(REQ_POP, 16'h0000, 8'sd0);
        queue_one(REQ_DELETE, 16'h0000, 8'sd0);
        queue_one(REQ_PUSH, 16'hffff, -8'sd1);
        queue_one(REQ_PUSH, 16'h0000, 8'sd0);
        queue_one(REQ_INSERT, 16'haaaa, 8'sd127);
        queue_one(REQ_INSERT, 16'h5555, -8'sd128);
        queue_one(REQ_INSERT, 16'h1234, 8'sd0);
        queue_one(REQ_INSERT, 16'h4321, 8'sd127);
        for (int i = 0; i < 10; i++)
            queue_one(REQ_INSERT, 16'(16'h0100 + i), fill_pris[i]);
        queue_one(REQ_PUSH, 16'hbeef, 8'sd0);
        queue_one(REQ_INSERT, 16'hcafe, 8'sd127);
        queue_one(REQ_DELETE, 16'h0000, 8'sd0);
        queue_one(REQ_DELETE, 16'h0000, 8'sd55);
        queue_one(REQ_POP, 16'h0000, 8'sd0);
        queue_one(REQ_POP, 16'h0000, 8'sd0);
        wait_drained();

        // balanced random traffic
        queue_random(500, 25, 30, 30);
        wait_drained();

        // receiver holds off while adds keep coming
        rx_hold_left = 400;
        queue_random(120, 35, 10, 45);
        wait_drained();

        // no idling on either side
        idle_pct = 0;
        queue_random(400, 25, 30, 30);
        wait_drained();
        idle_pct = 38;

        // fill-heavy then drain-heavy, then balanced again
        queue_random(350, 35, 10, 45);
        queue_random(350, 10, 60, 15);
        wait_drained();
        queue_random(300, 20, 30, 30);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (replies_due.size() != 0) mismatches += replies_due.size();

        $display("requests: push %0d, pop %0d, insert %0d, delete %0d (%0d with matches)",
                 ops_seen[REQ_PUSH], ops_seen[REQ_POP], ops_seen[REQ_INSERT],
                 ops_seen[REQ_DELETE], delete_hits);
        $display("full rejections %0d, empty pops %0d, peak fill %0d, mismatches %0d",
                 full_rejects, empty_pops, peak_fill, mismatches);
        if (mismatches == 0) begin
            $display("** bounded_priority_queue_core: PASSED **");
        end else begin
            $display("** bounded_priority_queue_core: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("timeout waiting for the queue core");
        $display("** bounded_priority_queue_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
